// ----- hw/rtl/sfd_pkg.sv -----
package sfd_pkg;

  localparam int unsigned WinLen     = 43;
  localparam int unsigned NumFields  = 12;
  localparam int unsigned NumResults = NumFields + 1;
  localparam int unsigned CntW       = $clog2(WinLen + 1);
  localparam int unsigned RemW       = $clog2(NumResults + 1);
  localparam int unsigned IdxW       = 4;
  localparam int unsigned ValW       = 24;

  localparam logic [IdxW-1:0] LastIndex = IdxW'(NumFields);

  localparam logic [7:0] SyncByte = 8'h55;
  localparam logic [7:0] GyroId   = 8'h51;
  localparam logic [7:0] AccelId  = 8'h52;
  localparam logic [7:0] AngleId  = 8'h53;

  localparam int unsigned FieldOffset [NumFields] = '{
    2, 5, 8, 13, 16, 19, 24, 27, 30, 33, 36, 39
  };

  typedef logic [7:0]      byte_t;
  typedef logic [ValW-1:0] value_t;

  typedef struct packed {
    logic load;
    logic shift;
  } res_ctrl_t;

endpackage

// ----- hw/rtl/sfd_byte_cell.sv -----
module sfd_byte_cell (
  input  logic          clk,
  input  logic          shift,
  input  sfd_pkg::byte_t din,
  output sfd_pkg::byte_t dout
);

  sfd_pkg::byte_t data;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= din;
    end
  end

  assign dout = data;

endmodule

// ----- hw/rtl/sfd_result_cell.sv -----
module sfd_result_cell (
  input  logic               clk,
  input  sfd_pkg::res_ctrl_t ctrl,
  input  sfd_pkg::value_t    load_val,
  input  sfd_pkg::value_t    din,
  output sfd_pkg::value_t    dout
);

  sfd_pkg::value_t data;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_val;
    end else if (ctrl.shift) begin
      data <= din;
    end
  end

  assign dout = data;

endmodule

// ----- hw/rtl/sensor_frame_deframer_top.sv -----
// sensor frame deframer
// input stream: one received serial byte per transaction on s_tdata[7:0].
// the bytes shift through a row of 43 byte cells; when the window holds the
// three sync pairs 55 51 / 55 52 / 55 53 at bytes 0, 11 and 22 and at least
// 43 bytes have arrived since reset or since the previous frame, the frame
// is taken in the same cycle the last byte is accepted.
// output stream: 13 transactions per frame, field index in m_tdata[3:0],
// value in m_tdata[27:4]; m_tlast marks the status byte (index 12).
// the first result is valid in the cycle after the frame's last byte is
// accepted; the 13 results then leave one per cycle while m_tready is
// high, from a row of 13 result cells that shift toward the output.
// throughput: one byte per cycle while s_tready is high. s_tready drops only when the byte that
// could complete a new frame arrives while results of the previous frame
// are still waiting; that is the only coupling between the two sides.
// when the receiver stalls, the current result holds and bytes keep
// flowing until that point.
// reset clears the window to zeros, the byte count and the result count.
module sensor_frame_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] field_index, [27:4] field_value
  output logic        m_tlast
);

  localparam int unsigned WinLen     = sfd_pkg::WinLen;
  localparam int unsigned NumResults = sfd_pkg::NumResults;
  localparam int unsigned CntW       = sfd_pkg::CntW;
  localparam int unsigned RemW       = sfd_pkg::RemW;
  localparam int unsigned IdxW       = sfd_pkg::IdxW;
  localparam int unsigned ValW       = sfd_pkg::ValW;

  sfd_pkg::byte_t  win     [WinLen];
  sfd_pkg::value_t res     [NumResults];
  sfd_pkg::value_t res_val [NumResults];

  logic [CntW-1:0] cnt, cnt_next, cnt_inc;
  logic [RemW-1:0] rem, rem_next;
  logic            s_acc, m_acc, hdr_ok, frame;
  sfd_pkg::res_ctrl_t res_ctrl;
  logic [IdxW-1:0] idx;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  // a byte that can close a frame waits until the result row is empty
  assign s_tready = (rem == '0) || (cnt < CntW'(WinLen - 1));

  // window byte i after the shift sits in cell i+1 now
  assign hdr_ok = (win[1]  == sfd_pkg::SyncByte) && (win[2]  == sfd_pkg::GyroId) &&
                  (win[12] == sfd_pkg::SyncByte) && (win[13] == sfd_pkg::AccelId) &&
                  (win[23] == sfd_pkg::SyncByte) && (win[24] == sfd_pkg::AngleId);

  assign cnt_inc = (cnt < CntW'(WinLen)) ? cnt + 1'b1 : cnt;
  assign frame   = s_acc && (cnt_inc == CntW'(WinLen)) && hdr_ok;

  always_comb begin
    cnt_next = cnt;
    if (s_acc) begin
      cnt_next = frame ? '0 : cnt_inc;
    end
  end

  always_comb begin
    rem_next = rem;
    if (frame) begin
      rem_next = RemW'(NumResults);
    end else if (m_acc) begin
      rem_next = rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rem <= '0;
    end else begin
      cnt <= cnt_next;
      rem <= rem_next;
    end
  end

  // byte cells: newest enters at the top, oldest at cell 0
  genvar i;
  generate
    for (i = 0; i < WinLen; i++) begin : g_win
      sfd_pkg::byte_t din;
      logic           sh;
      if (i == WinLen - 1) begin : g_top
        assign din = rst ? '0 : s_tdata;
      end else begin : g_mid
        assign din = rst ? '0 : win[i+1];
      end
      assign sh = rst || s_acc;
      sfd_byte_cell u_cell (
        .clk  (clk),
        .shift(sh),
        .din  (din),
        .dout (win[i])
      );
    end
  endgenerate

  assign res_ctrl.load  = frame;
  assign res_ctrl.shift = m_acc;

  // result cells: cell 0 drives the output
  genvar k;
  generate
    for (k = 0; k < NumResults; k++) begin : g_res
      sfd_pkg::value_t din;
      if (k == NumResults - 1) begin : g_stat
        assign res_val[k] = {(ValW - 8)'(0), s_tdata};
        assign din        = '0;
      end else begin : g_fld
        localparam int unsigned Off = sfd_pkg::FieldOffset[k];
        assign res_val[k] = {win[Off+3], win[Off+2], win[Off+1]};
        assign din        = res[k+1];
      end
      sfd_result_cell u_cell (
        .clk     (clk),
        .ctrl    (res_ctrl),
        .load_val(res_val[k]),
        .din     (din),
        .dout    (res[k])
      );
    end
  endgenerate

  assign idx      = IdxW'(RemW'(NumResults) - rem);
  assign m_tvalid = (rem != '0);
  assign m_tlast  = (rem == RemW'(1));
  assign m_tdata  = {(32 - IdxW - ValW)'(0), res[0], idx};

endmodule

// ----- hw/rtl/sfd_checker.sv -----
module sfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // the last result carries the status index
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[3:0] == sfd_pkg::LastIndex)
    else $error("tlast on wrong index");

  // results of a frame follow without gaps, index counting up
  a_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[3:0] == 4'($past(m_tdata[3:0]) + 4'd1)))
    else $error("frame results out of order");

  // a frame always starts at index zero
  a_first: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> m_tdata[3:0] == '0)
    else $error("frame did not start at index zero");

  // input never blocked while no result is pending
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with no result pending");

endmodule

bind sensor_frame_deframer_top sfd_checker u_sfd_checker (.*);

// ----- tb/sv/sensor_frame_deframer_top_test.sv -----
`timescale 1ns / 100ps

module sensor_frame_deframer_top_test;

  localparam int unsigned TailItems = 60;
  localparam int unsigned RandomItems = 90;

  typedef struct packed {
    logic [sfd_pkg::IdxW-1:0] idx;
    sfd_pkg::value_t          val;
    logic                     last;
  } field_rec_t;

  typedef struct packed {
    logic           drain;
    sfd_pkg::byte_t data;
  } rx_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [3:0] field_index, [27:4] field_value
  logic        m_tlast;

  rx_entry_t  rx_queue [$];
  field_rec_t expected_fields [$];
  sfd_pkg::byte_t frame_win [sfd_pkg::WinLen];
  logic [sfd_pkg::CntW-1:0] bytes_seen;
  int unsigned mismatch_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  logic        tail_phase = 1'b0;

  sensor_frame_deframer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic shift_in_byte(input sfd_pkg::byte_t b);
    field_rec_t rec;
    int unsigned o;
    for (int i = 0; i < sfd_pkg::WinLen - 1; i++) frame_win[i] = frame_win[i + 1];
    frame_win[sfd_pkg::WinLen - 1] = b;
    if (bytes_seen < sfd_pkg::WinLen) bytes_seen++;
    if (bytes_seen == sfd_pkg::WinLen &&
        frame_win[0] == sfd_pkg::SyncByte && frame_win[1] == sfd_pkg::GyroId &&
        frame_win[11] == sfd_pkg::SyncByte && frame_win[12] == sfd_pkg::AccelId &&
        frame_win[22] == sfd_pkg::SyncByte && frame_win[23] == sfd_pkg::AngleId) begin
      bytes_seen = '0;
      for (int k = 0; k < sfd_pkg::NumFields; k++) begin
        o = sfd_pkg::FieldOffset[k];
        rec.idx  = sfd_pkg::IdxW'(k);
        rec.val  = {frame_win[o + 2], frame_win[o + 1], frame_win[o]};
        rec.last = 1'b0;
        expected_fields.push_back(rec);
      end
      rec.idx  = sfd_pkg::LastIndex;
      rec.val  = sfd_pkg::value_t'(frame_win[sfd_pkg::WinLen - 1]);
      rec.last = 1'b1;
      expected_fields.push_back(rec);
    end
  endtask

  task automatic add_byte(input sfd_pkg::byte_t b, input logic drain);
    rx_entry_t e;
    e.data  = b;
    e.drain = drain;
    rx_queue.push_back(e);
  endtask

  // fill: 0 random, 1 all zeros, 2 all ones; bad_hdr picks a header byte to break
  task automatic queue_frame(input int fill, input int bad_hdr, input bit overlap,
                             input bit drain);
    sfd_pkg::byte_t f [sfd_pkg::WinLen];
    int unsigned hdr_pos [6];
    hdr_pos = '{0, 1, 11, 12, 22, 23};
    foreach (f[i]) begin
      case (fill)
        1: f[i] = 8'h00;
        2: f[i] = 8'hff;
        default: f[i] = sfd_pkg::byte_t'($urandom_range(0, 255));
      endcase
    end
    f[0]  = sfd_pkg::SyncByte;
    f[1]  = sfd_pkg::GyroId;
    f[11] = sfd_pkg::SyncByte;
    f[12] = sfd_pkg::AccelId;
    f[22] = sfd_pkg::SyncByte;
    f[23] = sfd_pkg::AngleId;
    // second header three bytes in, so a match shows up before 43 new bytes
    if (overlap) begin
      f[3]  = sfd_pkg::SyncByte;
      f[4]  = sfd_pkg::GyroId;
      f[14] = sfd_pkg::SyncByte;
      f[15] = sfd_pkg::AccelId;
      f[25] = sfd_pkg::SyncByte;
      f[26] = sfd_pkg::AngleId;
    end
    if (bad_hdr >= 0) f[hdr_pos[bad_hdr]] ^= sfd_pkg::byte_t'($urandom_range(1, 255));
    foreach (f[i]) add_byte(f[i], drain && i == 0);
    if (overlap) begin
      for (int i = 0; i < 3; i++) begin
        add_byte(sfd_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // rx byte driver
  always @(posedge clk) begin : rx_driver
    logic           nxt_valid;
    sfd_pkg::byte_t nxt_data;
    rx_entry_t      e;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      src_gap = 0;
    end else begin
      nxt_valid = s_tvalid;
      nxt_data = s_tdata;
      if (s_tvalid && s_tready) begin
        shift_in_byte(s_tdata);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (rx_queue.size() > 0 &&
                     !(rx_queue[0].drain && expected_fields.size() > 0)) begin
          if (!tail_phase && $urandom_range(0, 9) == 0) begin
            src_gap = $urandom_range(1, 14) - 1;
          end else begin
            e = rx_queue.pop_front();
            nxt_valid = 1'b1;
            nxt_data = e.data;
          end
        end
      end
      s_tvalid <= nxt_valid;
      s_tdata <= nxt_data;
      tail_phase <= rx_queue.size() < TailItems;
    end
  end

  // result monitor
  always @(posedge clk) begin : field_monitor
    field_rec_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_fields.size() == 0) begin
          note_mismatch($sformatf("unexpected transaction idx=%0d val=%06h last=%0b",
                                  m_tdata[3:0], m_tdata[27:4], m_tlast));
        end else begin
          want = expected_fields.pop_front();
          if (m_tdata[3:0] !== want.idx)
            note_mismatch($sformatf("field_index exp=%0d act=%0d", want.idx, m_tdata[3:0]));
          if (m_tdata[27:4] !== want.val)
            note_mismatch($sformatf("field_value idx=%0d exp=%06h act=%06h",
                                    want.idx, want.val, m_tdata[27:4]));
          if (m_tlast !== want.last)
            note_mismatch($sformatf("last_field idx=%0d exp=%0b act=%0b",
                                    want.idx, want.last, m_tlast));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned pick;
    int unsigned n;
    foreach (frame_win[i]) frame_win[i] = '0;
    bytes_seen = '0;

    // directed: extreme payloads, early match after a frame, broken sync, noise
    queue_frame(1, -1, 1'b0, 1'b0);
    queue_frame(2, -1, 1'b0, 1'b0);
    queue_frame(0, -1, 1'b1, 1'b0);
    queue_frame(0, 4, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(sfd_pkg::SyncByte, 1'b0);
    add_byte(sfd_pkg::GyroId, 1'b0);
    queue_frame(0, -1, 1'b0, 1'b1);

    rand_items = 0;
    while (rand_items < RandomItems) begin
      pick = $urandom_range(0, 99);
      n = rx_queue.size();
      if (pick < 60) begin
        queue_frame(0, -1, 1'b0, $urandom_range(0, 19) == 0);
      end else if (pick < 72) begin
        queue_frame(0, $urandom_range(0, 5), 1'b0, 1'b0);
      end else if (pick < 82) begin
        queue_frame(0, -1, 1'b1, 1'b0);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 3))
            0: add_byte(sfd_pkg::SyncByte, 1'b0);
            1: add_byte(sfd_pkg::byte_t'($urandom_range(sfd_pkg::GyroId, sfd_pkg::AngleId)),
                        1'b0);
            default: add_byte(sfd_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
          endcase
        end
      end
      rand_items += rx_queue.size() - n;
    end
    // make sure the sender waits for the receiver at least once mid-run
    queue_frame(0, -1, 1'b0, 1'b1);
    queue_frame(0, -1, 1'b0, 1'b0);

    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (rx_queue.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_fields.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (expected_fields.size() > 0) note_mismatch("expected results left over");
    if (mismatch_count == 0) begin
      $display("sensor_frame_deframer_top regression: pass");
    end else begin
      $display("sensor_frame_deframer_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sensor_frame_deframer_top regression: fail");
    $finish;
  end

endmodule
